[src/bsa_pkg.sv]
// package for the budgeted slot allocator
// beat types, status and kind codes, register map and sizing constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bsa_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int IDX_W      = 3;
	localparam int CNT_W      = 4;
	localparam int OWNER_W    = 32;
	localparam int BYTES_W    = 48;
	localparam int TALLY_W    = 32;
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;
	localparam int REG_SEL_W  = 3;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_EVICT   = 2'd2;
	localparam logic [1:0] KIND_NOP     = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NULL     = 3'd1;
	localparam logic [2:0] ST_BUDGET   = 3'd2;
	localparam logic [2:0] ST_NOSLOT   = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// register select, taken from paddr[5:3]
	localparam logic [REG_SEL_W-1:0] REG_SLOTS    = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_LIMIT    = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_ALLOCS   = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_RELEASES = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_EVICTS   = 3'd4;

	localparam logic [CNT_W-1:0]   SLOTS_RESET = 4'd8;
	localparam logic [BYTES_W-1:0] LIMIT_RESET = {BYTES_W{1'b1}};

	typedef struct packed {
		logic [1:0]         kind;
		logic [OWNER_W-1:0] owner_id;
		logic [BYTES_W-1:0] byte_count;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [2:0]         slot_index;
		logic [BYTES_W-1:0] freed_bytes;
		logic [BYTES_W-1:0] bytes_in_use;
		logic [CNT_W-1:0]   occupied_slots;
	} rsp_t;

	typedef struct packed {
		logic [CNT_W-1:0]   slots_in_use;
		logic [BYTES_W-1:0] hard_byte_limit;
	} cfg_t;

	typedef struct packed {
		logic [TALLY_W-1:0] allocs;
		logic [TALLY_W-1:0] releases;
		logic [TALLY_W-1:0] evicts;
	} tally_t;

endpackage

`default_nettype wire

[src/bsa_cfg_regs.sv]
// apb register file: slot limit and hard byte limit, read-only activity tallies
// depends on bsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsa_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bsa_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [bsa_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [bsa_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	input  wire bsa_pkg::tally_t                 tally,
	output bsa_pkg::cfg_t                        cfg
);
	import bsa_pkg::*;

	logic [REG_SEL_W-1:0] sel;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign sel    = paddr[APB_ADDR_W-1 -: REG_SEL_W];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slots_in_use    <= SLOTS_RESET;
			cfg_q.hard_byte_limit <= LIMIT_RESET;
		end else if (wr_en) begin
			if (sel == REG_SLOTS) begin
				cfg_q.slots_in_use <= pwdata[CNT_W-1:0];
			end
			if (sel == REG_LIMIT) begin
				cfg_q.hard_byte_limit <= pwdata[BYTES_W-1:0];
			end
		end
	end

	always_comb begin
		unique case (sel)
			REG_SLOTS:    prdata = APB_DATA_W'(cfg_q.slots_in_use);
			REG_LIMIT:    prdata = APB_DATA_W'(cfg_q.hard_byte_limit);
			REG_ALLOCS:   prdata = APB_DATA_W'(tally.allocs);
			REG_RELEASES: prdata = APB_DATA_W'(tally.releases);
			REG_EVICTS:   prdata = APB_DATA_W'(tally.evicts);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[src/budgeted_slot_allocator.sv]
// top level: first-fit slot table with a byte budget, one slot compare per cycle
// depends on bsa_pkg and bsa_cfg_regs
// sequence: accept, check state, then a scan from slot 0 for beats that pass the check,
// then a done state that registers the result; null, budget, no-op and empty-limit beats skip the scan
// one beat at a time: req_stall stays high from accept until the result beat is registered; one owner comparator
// reset: table, byte total, counters and tallies clear at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module budgeted_slot_allocator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire bsa_pkg::req_t                   req,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output bsa_pkg::rsp_t                        rsp,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [bsa_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [bsa_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [bsa_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready
);
	import bsa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t             state_q;
	cfg_t               cfg;
	tally_t             tally_q;
	req_t               req_q;
	logic [OWNER_W-1:0] slot_q [SLOT_COUNT];
	logic [BYTES_W-1:0] total_q;
	logic [CNT_W-1:0]   active_q;
	logic [IDX_W-1:0]   idx_q;
	logic [OWNER_W-1:0] target_q;
	logic [BYTES_W-1:0] arith_q;
	logic               borrow_q;
	logic [2:0]         status_q;
	logic [2:0]         slot_idx_q;
	logic [BYTES_W-1:0] freed_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic [CNT_W-1:0]   lim;
	logic               is_alloc;
	logic [BYTES_W:0]   au_res;
	logic               over;
	logic               hit;
	logic               last;
	logic               out_free;

	bsa_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.tally   (tally_q),
		.cfg     (cfg)
	);

	assign lim = (cfg.slots_in_use > CNT_W'(SLOT_COUNT)) ? CNT_W'(SLOT_COUNT)
		: cfg.slots_in_use;
	assign is_alloc = (req_q.kind == KIND_ALLOC);

	// shared add/subtract: new total on allocate, reduced total otherwise
	assign au_res = is_alloc ? ({1'b0, total_q} + {1'b0, req_q.byte_count})
		: ({1'b0, total_q} - {1'b0, req_q.byte_count});
	assign over   = au_res > {1'b0, cfg.hard_byte_limit};

	assign hit      = (slot_q[idx_q] == target_q);
	assign last     = ((CNT_W'(idx_q) + CNT_W'(1)) == lim);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			total_q     <= '0;
			active_q    <= '0;
			tally_q     <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_q[i] <= '0;
			end
		end else begin
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (req_q.kind == KIND_NOP || req_q.owner_id == '0
						|| (is_alloc && over) || lim == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						slot_q[idx_q] <= is_alloc ? req_q.owner_id : '0;
						if (is_alloc) begin
							total_q        <= arith_q;
							active_q       <= active_q + CNT_W'(1);
							tally_q.allocs <= tally_q.allocs + TALLY_W'(1);
						end else begin
							total_q <= borrow_q ? '0 : arith_q;
							if (active_q != '0) begin
								active_q <= active_q - CNT_W'(1);
							end
							if (req_q.kind == KIND_RELEASE) begin
								tally_q.releases <= tally_q.releases + TALLY_W'(1);
							end else begin
								tally_q.evicts <= tally_q.evicts + TALLY_W'(1);
							end
						end
						state_q <= S_DONE;
					end else if (last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_q <= req;
				end
			end
			S_CHECK: begin
				idx_q      <= '0;
				target_q   <= is_alloc ? '0 : req_q.owner_id;
				arith_q    <= au_res[BYTES_W-1:0];
				borrow_q   <= au_res[BYTES_W];
				slot_idx_q <= '0;
				freed_q    <= '0;
				if (req_q.kind == KIND_NOP) begin
					status_q <= ST_OK;
				end else if (req_q.owner_id == '0) begin
					status_q <= ST_NULL;
				end else if (is_alloc && over) begin
					status_q <= ST_BUDGET;
				end else begin
					status_q <= is_alloc ? ST_NOSLOT : ST_NOTFOUND;
				end
			end
			S_SCAN: begin
				idx_q <= idx_q + IDX_W'(1);
				if (hit) begin
					status_q <= ST_OK;
					if (is_alloc) begin
						slot_idx_q <= 3'(idx_q);
					end else begin
						freed_q <= req_q.byte_count;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					rsp_q.status         <= status_q;
					rsp_q.slot_index     <= slot_idx_q;
					rsp_q.freed_bytes    <= freed_q;
					rsp_q.bytes_in_use   <= total_q;
					rsp_q.occupied_slots <= active_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[src/bsa_checker.sv]
// port-level checks for the budgeted slot allocator, bound to the top level
// depends on bsa_pkg and budgeted_slot_allocator
`timescale 1ns / 1ps
`default_nettype none

module bsa_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire bsa_pkg::rsp_t rsp
);
	import bsa_pkg::*;

	// stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// one beat in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input accepted while previous beat in flight");

	// failed beats report no slot and no freed bytes
	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.slot_index == '0 && rsp.freed_bytes == '0)
		else $error("slot or freed bytes set on failed beat");

	// known status and bounded occupancy
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_NULL
			|| rsp.status == ST_BUDGET || rsp.status == ST_NOSLOT
			|| rsp.status == ST_NOTFOUND)
			&& rsp.occupied_slots <= CNT_W'(SLOT_COUNT))
		else $error("bad status or occupancy");

endmodule

bind budgeted_slot_allocator bsa_checker u_bsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

[dv/tb_top.sv]
// testbench for budgeted_slot_allocator: directed and random request beats are checked
// against an in-bench prediction of the slot table, byte total and slot count
// depends on bsa_pkg and the budgeted_slot_allocator rtl
`timescale 1ns / 1ps

module tb_top;

	import bsa_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 12;

	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [BYTES_W-1:0] size;
	} held_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// bench copy of the block state and registers
	logic [OWNER_W-1:0] slot_owner [SLOT_COUNT] = '{default: '0};
	logic [BYTES_W-1:0] byte_total = '0;
	logic [CNT_W-1:0] held_slots = '0;
	logic [CNT_W-1:0] cfg_slots = SLOTS_RESET;
	logic [BYTES_W-1:0] cfg_limit = LIMIT_RESET;

	req_t req_backlog [$];
	rsp_t awaited_rsp [$];
	held_t live [$];
	logic req_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int bad_beats = 0;
	int quiet_cycles = 0;

	budgeted_slot_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rsp_t alloc_predict(req_t r);
		rsp_t res;
		int lim;
		logic [BYTES_W:0] grown;
		res = '0;
		res.status = ST_OK;
		lim = (cfg_slots > SLOT_COUNT) ? SLOT_COUNT : int'(cfg_slots);
		grown = {1'b0, byte_total} + {1'b0, r.byte_count};
		if (r.kind == KIND_NOP) begin
			res.status = ST_OK;
		end else if (r.owner_id == '0) begin
			res.status = ST_NULL;
		end else if (r.kind == KIND_ALLOC) begin
			if (grown > {1'b0, cfg_limit}) begin
				res.status = ST_BUDGET;
			end else begin
				res.status = ST_NOSLOT;
				for (int i = 0; i < lim; i++) begin
					if (res.status == ST_NOSLOT && slot_owner[i] == '0) begin
						slot_owner[i] = r.owner_id;
						byte_total = grown[BYTES_W-1:0];
						held_slots = held_slots + CNT_W'(1);
						res.slot_index = IDX_W'(i);
						res.status = ST_OK;
					end
				end
			end
		end else begin
			res.status = ST_NOTFOUND;
			for (int i = 0; i < lim; i++) begin
				if (res.status == ST_NOTFOUND && slot_owner[i] == r.owner_id) begin
					slot_owner[i] = '0;
					byte_total = (r.byte_count <= byte_total) ? byte_total - r.byte_count : '0;
					if (held_slots != '0)
						held_slots = held_slots - CNT_W'(1);
					res.freed_bytes = r.byte_count;
					res.status = ST_OK;
				end
			end
		end
		res.bytes_in_use = byte_total;
		res.occupied_slots = held_slots;
		return res;
	endfunction

	function automatic logic [BYTES_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[BYTES_W-1:0];
	endfunction

	function automatic logic [BYTES_W-1:0] pick_size();
		logic [63:0] span;
		int r;
		r = $urandom_range(9);
		span = {16'd0, cfg_limit} + 64'd1;
		if (r == 0)
			return '0;
		else if (r <= 5)
			return BYTES_W'($urandom_range(400));
		else if (r <= 7)
			return BYTES_W'({16'd0, rand48()} % ((span >> 2) + 64'd1));
		else if (r == 8)
			return rand48();
		else
			return BYTES_W'({16'd0, rand48()} % span);
	endfunction

	task automatic push_req(logic [1:0] kind, logic [OWNER_W-1:0] owner,
			logic [BYTES_W-1:0] size);
		req_t item;
		item.kind = kind;
		item.owner_id = owner;
		item.byte_count = size;
		req_backlog.push_back(item);
	endtask

	task automatic apb_write(logic [REG_SEL_W-1:0] sel, logic [APB_DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 3'b000};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_drained();
		while (req_backlog.size() != 0 || req_valid || awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [CNT_W-1:0] slots, logic [BYTES_W-1:0] limit,
			int send_pct, int stall_pct, int count);
		req_t item;
		held_t h;
		int roll;
		int pos;
		wait_drained();
		apb_write(REG_SLOTS, {{(APB_DATA_W-CNT_W){1'b0}}, slots});
		cfg_slots = slots;
		apb_write(REG_LIMIT, {{(APB_DATA_W-BYTES_W){1'b0}}, limit});
		cfg_limit = limit;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			item.kind = KIND_ALLOC;
			item.owner_id = $urandom_range(12, 1);
			item.byte_count = pick_size();
			if (live.size() >= 12 || (roll >= 40 && roll < 75)) begin
				if (live.size() != 0) begin
					pos = $urandom_range(live.size() - 1);
					item.kind = 2'($urandom_range(KIND_EVICT, KIND_RELEASE));
					item.owner_id = live[pos].owner;
					item.byte_count = live[pos].size;
					live.delete(pos);
				end
			end else if (roll >= 75 && roll < 82) begin
				item.kind = 2'($urandom_range(KIND_EVICT, KIND_RELEASE));
			end else if (roll >= 82 && roll < 87) begin
				item.kind = 2'($urandom_range(KIND_EVICT, KIND_ALLOC));
				item.owner_id = '0;
				item.byte_count = rand48();
			end else if (roll >= 87 && roll < 91) begin
				item.kind = KIND_NOP;
				item.owner_id = $urandom;
				item.byte_count = rand48();
			end else if (roll >= 91 && roll < 96) begin
				item.owner_id = $urandom;
				item.byte_count = rand48();
			end else if (roll >= 96) begin
				item.kind = 2'($urandom_range(KIND_EVICT, KIND_RELEASE));
				item.byte_count = rand48();
			end
			if (item.kind == KIND_ALLOC && item.owner_id != '0) begin
				h.owner = item.owner_id;
				h.size = item.byte_count;
				live.push_back(h);
			end
			req_backlog.push_back(item);
		end
	endtask

	// driver: request beats and response stall change on the falling edge
	always @(negedge clk) begin
		if (!(req_valid && !req_taken)) begin
			if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req <= req_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: predict on each accepted request beat, check each accepted result beat
	always @(posedge clk) begin : observe
		rsp_t want;
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall)
				awaited_rsp.push_back(alloc_predict(req));
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsp.size() == 0) begin
					if (bad_beats < 10)
						$display("unexpected result beat: status %0d", rsp.status);
					bad_beats++;
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.status !== want.status || rsp.slot_index !== want.slot_index
							|| rsp.freed_bytes !== want.freed_bytes
							|| rsp.bytes_in_use !== want.bytes_in_use
							|| rsp.occupied_slots !== want.occupied_slots) begin
						if (bad_beats < 10)
							$display("mismatch exp/act: status %0d/%0d slot %0d/%0d freed %0h/%0h",
								want.status, rsp.status, want.slot_index, rsp.slot_index,
								want.freed_bytes, rsp.freed_bytes,
								"\n  in_use %0h/%0h occupied %0d/%0d",
								want.bytes_in_use, rsp.bytes_in_use,
								want.occupied_slots, rsp.occupied_slots);
						bad_beats++;
					end
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, null owner, no-op, duplicates, oversized release, full table
		push_req(KIND_ALLOC, 32'hFFFF_FFFF, '0);
		push_req(KIND_ALLOC, 32'd1, LIMIT_RESET);
		push_req(KIND_ALLOC, 32'd2, 48'd1);
		push_req(KIND_ALLOC, '0, LIMIT_RESET);
		push_req(KIND_RELEASE, '0, 48'd7);
		push_req(KIND_EVICT, '0, '0);
		push_req(KIND_NOP, 32'hA5A5_5A5A, LIMIT_RESET);
		push_req(KIND_RELEASE, 32'd5, 48'd3);
		push_req(KIND_ALLOC, 32'd1, '0);
		push_req(KIND_RELEASE, 32'd1, 48'd5);
		push_req(KIND_EVICT, 32'd1, LIMIT_RESET);
		push_req(KIND_EVICT, 32'hFFFF_FFFF, '0);
		for (int k = 3; k <= 11; k++)
			push_req(KIND_ALLOC, OWNER_W'(k), 48'd1);
		push_req(KIND_RELEASE, 32'd10, 48'd1);

		run_phase(4'd8, LIMIT_RESET, 0, 0, 180);
		run_phase(4'd1, LIMIT_RESET, 45, 0, 180);
		run_phase(4'd3, 48'd1000, 0, 45, 180);
		run_phase(4'd0, LIMIT_RESET, 32, 32, 150);
		run_phase(4'd15, 48'h10_0000, 0, 0, 180);
		run_phase(4'd5, 48'd0, 45, 0, 150);
		run_phase(4'd8, 48'h100_0000_0000, 0, 45, 200);
		run_phase(4'd12, LIMIT_RESET, 32, 32, 200);
		run_phase(4'd2, 48'd5000, 32, 32, 180);
		wait_drained();

		if (bad_beats == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
